FILE: hw/rtl/mmf_pkg.sv
package mmf_pkg;

    typedef enum logic [2:0] {
        REQ_PUT   = 3'd0,
        REQ_GET   = 3'd1,
        REQ_FLUSH = 3'd2,
        REQ_PURGE = 3'd3,
        REQ_ABORT = 3'd4,
        REQ_START = 3'd5
    } t_req;

    typedef enum logic [2:0] {
        STS_DONE    = 3'd0,
        STS_MSG     = 3'd1,
        STS_EMPTY   = 3'd2,
        STS_ABORTED = 3'd3,
        STS_FULL    = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PURGE,
        S_SECOND
    } t_state;

    typedef enum logic [1:0] {
        OP_NOP,
        OP_WRITE,
        OP_SHIFT,
        OP_ROTATE
    } t_chain_op;

    typedef struct packed {
        logic signed [31:0] msg_type;
        logic signed [31:0] arg_a;
        logic signed [31:0] arg_b;
    } t_msg;

    typedef struct packed {
        t_chain_op op;
        t_msg      wr_data;
    } t_chain_ctl;

    typedef struct packed {
        t_status            status;
        logic signed [31:0] out_type;
        logic signed [31:0] out_arg_a;
        logic signed [31:0] out_arg_b;
        logic               last_result;
    } t_rsp;

endpackage

FILE: hw/rtl/mmf_if.sv
interface mmf_req_if;
    logic               valid;
    logic               ready;
    logic [2:0]         req_type;
    logic signed [31:0] msg_type;
    logic signed [31:0] msg_arg_a;
    logic signed [31:0] msg_arg_b;
    logic               wait_flag;

    modport source (
        output valid, req_type, msg_type, msg_arg_a, msg_arg_b, wait_flag,
        input  ready
    );
    modport sink (
        input  valid, req_type, msg_type, msg_arg_a, msg_arg_b, wait_flag,
        output ready
    );
endinterface

interface mmf_rsp_if;
    logic               valid;
    logic               ready;
    logic [2:0]         status;
    logic signed [31:0] out_type;
    logic signed [31:0] out_arg_a;
    logic signed [31:0] out_arg_b;
    logic [6:0]         queued_count;
    logic               last_result;

    modport source (
        output valid, status, out_type, out_arg_a, out_arg_b, queued_count, last_result,
        input  ready
    );
    modport sink (
        input  valid, status, out_type, out_arg_a, out_arg_b, queued_count, last_result,
        output ready
    );
endinterface

FILE: hw/rtl/mmf_cell.sv
module mmf_cell #(
    parameter int CNT_W = 7,
    parameter int IDX   = 0
) (
    input  logic                i_clk,
    input  mmf_pkg::t_chain_ctl i_ctl,
    input  logic [CNT_W-1:0]    i_count,
    input  mmf_pkg::t_msg       i_next_data,
    input  mmf_pkg::t_msg       i_head_data,
    output mmf_pkg::t_msg       o_data
);

    localparam logic [CNT_W-1:0] POS  = CNT_W'(IDX);
    localparam logic [CNT_W-1:0] TAIL = CNT_W'(IDX + 1);

    mmf_pkg::t_msg r_data;
    mmf_pkg::t_msg n_data;

    always_comb begin
        n_data = r_data;
        case (i_ctl.op)
            mmf_pkg::OP_WRITE: begin
                if (i_count == POS) begin
                    n_data = i_ctl.wr_data;
                end
            end
            mmf_pkg::OP_SHIFT: begin
                n_data = i_next_data;
            end
            mmf_pkg::OP_ROTATE: begin
                n_data = (i_count == TAIL) ? i_head_data : i_next_data;
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

FILE: hw/rtl/mmf_chain.sv
module mmf_chain #(
    parameter int DEPTH = 64,
    parameter int CNT_W = 7
) (
    input  logic                i_clk,
    input  mmf_pkg::t_chain_ctl i_ctl,
    input  logic [CNT_W-1:0]    i_count,
    output mmf_pkg::t_msg       o_head
);

    mmf_pkg::t_msg w_data [DEPTH];

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        mmf_pkg::t_msg w_next;
        if (g == DEPTH - 1) begin : g_last
            assign w_next = w_data[g];
        end else begin : g_mid
            assign w_next = w_data[g + 1];
        end
        mmf_cell #(
            .CNT_W(CNT_W),
            .IDX  (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_ctl      (i_ctl),
            .i_count    (i_count),
            .i_next_data(w_next),
            .i_head_data(w_data[0]),
            .o_data     (w_data[g])
        );
    end

    assign o_head = w_data[0];

endmodule

FILE: hw/rtl/message_mailbox_fifo.sv
// Mailbox FIFO of (type, arg_a, arg_b) messages held in a row of cells, head at
// cell 0. Put, get, flush, abort and start are each taken at the request
// port while the response register is free; a request with two results holds
// the port until the second is loaded. Purge by type walks the row once,
// rotating the head entry to the tail or dropping it, and holds the port
// until done. A waiting get on an empty mailbox returns nothing until a
// put, start or abort answers it. After reset the mailbox is aborted.
module message_mailbox_fifo #(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    mmf_req_if.sink            i_req,
    mmf_rsp_if.source          o_rsp,
    input  logic               i_cfg_wr_en,
    input  logic signed [31:0] i_cfg_wr_data
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    mmf_pkg::t_state     r_state, n_state;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [CNT_W-1:0]    r_scan, n_scan;
    logic                r_aborted, n_aborted;
    logic                r_pending, n_pending;
    logic signed [31:0]  r_marker_type;
    logic signed [31:0]  r_purge_type, n_purge_type;
    logic                r_out_valid, n_out_valid;
    mmf_pkg::t_rsp       r_out, n_out;
    logic [6:0]          r_out_count, n_out_count;
    mmf_pkg::t_rsp       r_second, n_second;

    mmf_pkg::t_chain_ctl w_ctl;
    mmf_pkg::t_msg       w_head;
    mmf_pkg::t_msg       w_in_msg;
    mmf_pkg::t_msg       w_marker;
    logic                w_out_free;
    logic                w_accept;
    logic                w_load;
    logic [CNT_W+6:0]    w_count_ext;

    mmf_chain #(
        .DEPTH(QUEUE_DEPTH),
        .CNT_W(CNT_W)
    ) u_chain (
        .i_clk  (i_clk),
        .i_ctl  (w_ctl),
        .i_count(r_count),
        .o_head (w_head)
    );

    assign w_out_free  = !r_out_valid || o_rsp.ready;
    assign i_req.ready = (r_state == mmf_pkg::S_IDLE) && w_out_free;
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_in_msg    = '{msg_type: i_req.msg_type, arg_a: i_req.msg_arg_a,
                           arg_b: i_req.msg_arg_b};
    assign w_marker    = '{msg_type: r_marker_type, arg_a: 32'sd0, arg_b: 32'sd0};
    assign w_count_ext = {7'd0, n_count};

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_scan       = r_scan;
        n_aborted    = r_aborted;
        n_pending    = r_pending;
        n_purge_type = r_purge_type;
        n_second     = r_second;
        n_out        = r_out;
        n_out_count  = r_out_count;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        w_ctl        = '{op: mmf_pkg::OP_NOP, wr_data: w_in_msg};
        w_load       = 1'b0;

        unique case (r_state)
            mmf_pkg::S_IDLE: begin
                if (w_accept) begin
                    w_load = 1'b1;
                    n_out  = '{status: mmf_pkg::STS_DONE, out_type: 32'sd0,
                               out_arg_a: 32'sd0, out_arg_b: 32'sd0, last_result: 1'b1};
                    unique case (mmf_pkg::t_req'(i_req.req_type))
                        mmf_pkg::REQ_PUT, mmf_pkg::REQ_START: begin
                            if (mmf_pkg::t_req'(i_req.req_type) == mmf_pkg::REQ_START) begin
                                n_aborted     = 1'b0;
                                w_ctl.wr_data = w_marker;
                            end
                            if (r_aborted &&
                                mmf_pkg::t_req'(i_req.req_type) == mmf_pkg::REQ_PUT) begin
                                n_out.status = mmf_pkg::STS_ABORTED;
                            end else if (r_count == FULL_CNT) begin
                                n_out.status = mmf_pkg::STS_FULL;
                            end else if (r_pending) begin
                                // mailbox is empty: hand the new message straight over
                                n_pending         = 1'b0;
                                n_out.last_result = 1'b0;
                                n_second = '{status: mmf_pkg::STS_MSG,
                                             out_type: w_ctl.wr_data.msg_type,
                                             out_arg_a: w_ctl.wr_data.arg_a,
                                             out_arg_b: w_ctl.wr_data.arg_b,
                                             last_result: 1'b1};
                                n_state  = mmf_pkg::S_SECOND;
                            end else begin
                                w_ctl.op = mmf_pkg::OP_WRITE;
                                n_count  = r_count + 1'b1;
                            end
                        end
                        mmf_pkg::REQ_GET: begin
                            if (r_aborted) begin
                                n_out.status = mmf_pkg::STS_ABORTED;
                            end else if (r_count != '0) begin
                                n_out.status    = mmf_pkg::STS_MSG;
                                n_out.out_type  = w_head.msg_type;
                                n_out.out_arg_a = w_head.arg_a;
                                n_out.out_arg_b = w_head.arg_b;
                                w_ctl.op        = mmf_pkg::OP_SHIFT;
                                n_count         = r_count - 1'b1;
                            end else if (i_req.wait_flag) begin
                                n_pending = 1'b1;
                                w_load    = 1'b0;
                            end else begin
                                n_out.status = mmf_pkg::STS_EMPTY;
                            end
                        end
                        mmf_pkg::REQ_FLUSH: begin
                            n_count = '0;
                        end
                        mmf_pkg::REQ_PURGE: begin
                            if (!r_aborted && r_count != '0) begin
                                n_purge_type = i_req.msg_type;
                                n_scan       = r_count;
                                n_state      = mmf_pkg::S_PURGE;
                                w_load       = 1'b0;
                            end
                        end
                        mmf_pkg::REQ_ABORT: begin
                            n_aborted = 1'b1;
                            if (r_pending) begin
                                n_pending         = 1'b0;
                                n_out.last_result = 1'b0;
                                n_second = '{status: mmf_pkg::STS_ABORTED, out_type: 32'sd0,
                                             out_arg_a: 32'sd0, out_arg_b: 32'sd0,
                                             last_result: 1'b1};
                                n_state  = mmf_pkg::S_SECOND;
                            end
                        end
                        default: begin
                            n_out.status = mmf_pkg::STS_DONE;
                        end
                    endcase
                end
            end
            mmf_pkg::S_PURGE: begin
                if (r_scan != '0) begin
                    n_scan = r_scan - 1'b1;
                    if (w_head.msg_type == r_purge_type) begin
                        w_ctl.op = mmf_pkg::OP_SHIFT;
                        n_count  = r_count - 1'b1;
                    end else begin
                        w_ctl.op = mmf_pkg::OP_ROTATE;
                    end
                end else if (w_out_free) begin
                    w_load  = 1'b1;
                    n_out   = '{status: mmf_pkg::STS_DONE, out_type: 32'sd0,
                                out_arg_a: 32'sd0, out_arg_b: 32'sd0, last_result: 1'b1};
                    n_state = mmf_pkg::S_IDLE;
                end
            end
            mmf_pkg::S_SECOND: begin
                if (w_out_free) begin
                    w_load  = 1'b1;
                    n_out   = r_second;
                    n_state = mmf_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = mmf_pkg::S_IDLE;
            end
        endcase

        if (w_load) begin
            n_out_valid = 1'b1;
            n_out_count = w_count_ext[6:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= mmf_pkg::S_IDLE;
            r_count       <= '0;
            r_scan        <= '0;
            r_aborted     <= 1'b1;
            r_pending     <= 1'b0;
            r_marker_type <= 32'sd0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_scan      <= n_scan;
            r_aborted   <= n_aborted;
            r_pending   <= n_pending;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_marker_type <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_purge_type <= n_purge_type;
        r_second     <= n_second;
        r_out        <= n_out;
        r_out_count  <= n_out_count;
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_out.status;
    assign o_rsp.out_type     = r_out.out_type;
    assign o_rsp.out_arg_a    = r_out.out_arg_a;
    assign o_rsp.out_arg_b    = r_out.out_arg_b;
    assign o_rsp.queued_count = r_out_count;
    assign o_rsp.last_result  = r_out.last_result;

endmodule

FILE: verif/message_mailbox_fifo_tb.sv
`timescale 1ns / 1ps

module message_mailbox_fifo_tb;

    localparam int MBOX_DEPTH    = 64;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 400;
    localparam int STALL_LIMIT   = 3000;
    localparam int MAX_REPORTS   = 10;
    localparam logic [2:0] REQ_UNKNOWN_6 = 3'd6;
    localparam logic [2:0] REQ_UNKNOWN_7 = 3'd7;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] mtype;
        logic [31:0] arg_a;
        logic [31:0] arg_b;
        logic [6:0]  count;
        logic        last;
    } t_mbox_rsp;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        cfg_wr_en;
    logic [31:0] cfg_wr_data;

    mmf_req_if req_bus ();
    mmf_rsp_if rsp_bus ();

    message_mailbox_fifo #(
        .QUEUE_DEPTH(MBOX_DEPTH)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (req_bus),
        .o_rsp         (rsp_bus),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data)
    );

    always #5 i_clk = ~i_clk;

    // mailbox shadow state
    mmf_pkg::t_msg mbox_msgs [$];
    logic          mbox_aborted = 1'b1;
    logic          get_waiting  = 1'b0;
    logic [31:0]   marker_type  = '0;
    t_mbox_rsp     pending_rsps [$];

    int          mismatch_count = 0;
    int          stall_left     = 0;
    bit          hold_off_req   = 1'b0;
    bit          quiet          = 1'b0;
    t_mbox_rsp   rsp_got;
    t_mbox_rsp   rsp_want;

    function automatic logic [2:0] store_msg(input logic [31:0] mt, ma, mb);
        mmf_pkg::t_msg m;
        if (mbox_msgs.size() >= MBOX_DEPTH) begin
            return mmf_pkg::STS_FULL;
        end
        m.msg_type = mt;
        m.arg_a    = ma;
        m.arg_b    = mb;
        mbox_msgs.push_back(m);
        return mmf_pkg::STS_DONE;
    endfunction

    task automatic predict_mailbox_step(input logic [2:0] req, input logic [31:0] mt, ma, mb,
                                        input logic wflag);
        t_mbox_rsp     rsp [2];
        mmf_pkg::t_msg head;
        mmf_pkg::t_msg kept [$];
        logic [2:0]    st;
        int            n;
        n = 1;
        rsp[0] = '0;
        rsp[1] = '0;
        case (req)
            mmf_pkg::REQ_PUT, mmf_pkg::REQ_START: begin
                if (req == mmf_pkg::REQ_START) begin
                    mbox_aborted = 1'b0;
                    st = store_msg(marker_type, '0, '0);
                end else if (mbox_aborted) begin
                    st = mmf_pkg::STS_ABORTED;
                end else begin
                    st = store_msg(mt, ma, mb);
                end
                rsp[0].status = st;
                if (st == mmf_pkg::STS_DONE && get_waiting && mbox_msgs.size() > 0) begin
                    head = mbox_msgs.pop_front();
                    rsp[1].status = mmf_pkg::STS_MSG;
                    rsp[1].mtype  = head.msg_type;
                    rsp[1].arg_a  = head.arg_a;
                    rsp[1].arg_b  = head.arg_b;
                    get_waiting = 1'b0;
                    n = 2;
                end
            end
            mmf_pkg::REQ_GET: begin
                if (mbox_aborted) begin
                    rsp[0].status = mmf_pkg::STS_ABORTED;
                end else if (mbox_msgs.size() > 0) begin
                    head = mbox_msgs.pop_front();
                    rsp[0].status = mmf_pkg::STS_MSG;
                    rsp[0].mtype  = head.msg_type;
                    rsp[0].arg_a  = head.arg_a;
                    rsp[0].arg_b  = head.arg_b;
                end else if (wflag) begin
                    get_waiting = 1'b1;
                    n = 0;
                end else begin
                    rsp[0].status = mmf_pkg::STS_EMPTY;
                end
            end
            mmf_pkg::REQ_FLUSH: begin
                mbox_msgs.delete();
                rsp[0].status = mmf_pkg::STS_DONE;
            end
            mmf_pkg::REQ_PURGE: begin
                if (!mbox_aborted) begin
                    foreach (mbox_msgs[i]) begin
                        if (mbox_msgs[i].msg_type != mt) begin
                            kept.push_back(mbox_msgs[i]);
                        end
                    end
                    mbox_msgs = kept;
                end
                rsp[0].status = mmf_pkg::STS_DONE;
            end
            mmf_pkg::REQ_ABORT: begin
                mbox_aborted = 1'b1;
                rsp[0].status = mmf_pkg::STS_DONE;
                if (get_waiting) begin
                    rsp[1].status = mmf_pkg::STS_ABORTED;
                    get_waiting = 1'b0;
                    n = 2;
                end
            end
            default: begin
                rsp[0].status = mmf_pkg::STS_DONE;
            end
        endcase
        for (int k = 0; k < n; k++) begin
            rsp[k].count = 7'(mbox_msgs.size());
            rsp[k].last  = (k == n - 1);
            pending_rsps.push_back(rsp[k]);
        end
    endtask

    function automatic int pick_gap();
        int r;
        if (quiet) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(6, 40);
    endfunction

    function automatic logic [31:0] pick_type();
        logic [31:0] pool [6];
        pool = '{32'd0, 32'd1, 32'd2, 32'd3, 32'h8000_0000, 32'h7fff_ffff};
        if ($urandom_range(0, 3) != 0) begin
            return pool[$urandom_range(0, 5)];
        end
        return $urandom;
    endfunction

    task automatic send_request(input logic [2:0] req, input logic [31:0] mt, ma, mb,
                                input logic wflag);
        int gap;
        req_bus.valid     <= 1'b1;
        req_bus.req_type  <= req;
        req_bus.msg_type  <= mt;
        req_bus.msg_arg_a <= ma;
        req_bus.msg_arg_b <= mb;
        req_bus.wait_flag <= wflag;
        do begin
            @(posedge i_clk);
        end while (!req_bus.ready);
        predict_mailbox_step(req, mt, ma, mb, wflag);
        gap = pick_gap();
        if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain_mailbox();
        req_bus.valid <= 1'b0;
        while (pending_rsps.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_marker(input logic [31:0] value);
        drain_mailbox();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        marker_type = value;
        @(posedge i_clk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic send_random_request();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40 || r >= 95) begin
            send_request(mmf_pkg::REQ_PUT, pick_type(), $urandom, $urandom,
                         1'($urandom_range(0, 1)));
        end else if (r < 68) begin
            send_request(mmf_pkg::REQ_GET, $urandom, $urandom, $urandom,
                         $urandom_range(0, 2) == 0);
        end else if (r < 76) begin
            send_request(mmf_pkg::REQ_PURGE, pick_type(), $urandom, $urandom,
                         1'($urandom_range(0, 1)));
        end else if (r < 84) begin
            send_request(mmf_pkg::REQ_START, $urandom, $urandom, $urandom,
                         1'($urandom_range(0, 1)));
        end else if (r < 88) begin
            send_request(mmf_pkg::REQ_FLUSH, $urandom, $urandom, $urandom,
                         1'($urandom_range(0, 1)));
        end else if (r < 93) begin
            send_request(mmf_pkg::REQ_ABORT, $urandom, $urandom, $urandom,
                         1'($urandom_range(0, 1)));
        end else begin
            send_request($urandom_range(0, 1) ? REQ_UNKNOWN_7 : REQ_UNKNOWN_6,
                         $urandom, $urandom, $urandom, 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic note_mismatch(input string what, input t_mbox_rsp want, got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("%s: exp sts=%0d type=%h a=%h b=%h cnt=%0d last=%0b", what,
                     want.status, want.mtype, want.arg_a, want.arg_b, want.count, want.last);
            $display("    got sts=%0d type=%h a=%h b=%h cnt=%0d last=%0b",
                     got.status, got.mtype, got.arg_a, got.arg_b, got.count, got.last);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_bus.valid && rsp_bus.ready) begin
            rsp_got.status = rsp_bus.status;
            rsp_got.mtype  = rsp_bus.out_type;
            rsp_got.arg_a  = rsp_bus.out_arg_a;
            rsp_got.arg_b  = rsp_bus.out_arg_b;
            rsp_got.count  = rsp_bus.queued_count;
            rsp_got.last   = rsp_bus.last_result;
            if (pending_rsps.size() == 0) begin
                note_mismatch("unexpected response", '0, rsp_got);
            end else begin
                rsp_want = pending_rsps.pop_front();
                if (rsp_got !== rsp_want) begin
                    note_mismatch("response mismatch", rsp_want, rsp_got);
                end
            end
        end
    end

    // response side back-pressure
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                stall_left = HOLD_CYCLES;
            end else if (!quiet && stall_left == 0 && $urandom_range(0, 99) < 2) begin
                stall_left = $urandom_range(8, 40);
            end
            if (stall_left > 0) begin
                stall_left--;
                rsp_bus.ready <= 1'b0;
            end else begin
                rsp_bus.ready <= quiet || ($urandom_range(0, 99) >= 25);
            end
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic test_aborted_after_reset();
        send_request(mmf_pkg::REQ_PUT, 32'd1, 32'd2, 32'd3, 1'b0);
        send_request(mmf_pkg::REQ_GET, '0, '0, '0, 1'b1);
        send_request(mmf_pkg::REQ_PURGE, 32'd1, '0, '0, 1'b0);
        send_request(mmf_pkg::REQ_FLUSH, '0, '0, '0, 1'b0);
        send_request(REQ_UNKNOWN_6, '1, '1, '1, 1'b1);
        send_request(REQ_UNKNOWN_7, '0, '0, '0, 1'b0);
    endtask

    task automatic test_marker_and_extremes();
        write_marker(32'h8000_0000);
        send_request(mmf_pkg::REQ_START, '1, '1, '1, 1'b1);
        send_request(mmf_pkg::REQ_PUT, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 1'b1);
        send_request(mmf_pkg::REQ_PUT, 32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 1'b0);
        send_request(mmf_pkg::REQ_GET, '0, '0, '0, 1'b0);
        send_request(mmf_pkg::REQ_GET, '0, '0, '0, 1'b1);
        send_request(mmf_pkg::REQ_GET, '0, '0, '0, 1'b0);
        send_request(mmf_pkg::REQ_GET, '0, '0, '0, 1'b0);
    endtask

    task automatic test_held_get();
        send_request(mmf_pkg::REQ_GET, '0, '0, '0, 1'b1);
        send_request(mmf_pkg::REQ_GET, '0, '0, '0, 1'b1);
        send_request(mmf_pkg::REQ_PUT, 32'd5, 32'd11, 32'd22, 1'b0);
        send_request(mmf_pkg::REQ_GET, '0, '0, '0, 1'b1);
        send_request(mmf_pkg::REQ_START, '0, '0, '0, 1'b0);
        send_request(mmf_pkg::REQ_GET, '0, '0, '0, 1'b1);
        send_request(mmf_pkg::REQ_FLUSH, '0, '0, '0, 1'b0);
        send_request(mmf_pkg::REQ_ABORT, '0, '0, '0, 1'b0);
    endtask

    task automatic test_purge_order();
        send_request(mmf_pkg::REQ_START, '0, '0, '0, 1'b0);
        send_request(mmf_pkg::REQ_PUT, 32'd1, 32'hdead_0001, 32'h0000_0001, 1'b0);
        send_request(mmf_pkg::REQ_PUT, 32'd2, 32'hdead_0002, 32'h0000_0002, 1'b0);
        send_request(mmf_pkg::REQ_PUT, 32'd1, 32'hdead_0003, 32'h0000_0003, 1'b0);
        send_request(mmf_pkg::REQ_PURGE, 32'd1, '0, '0, 1'b0);
        send_request(mmf_pkg::REQ_PURGE, 32'h8000_0000, '0, '0, 1'b0);
        send_request(mmf_pkg::REQ_GET, '0, '0, '0, 1'b0);
        send_request(mmf_pkg::REQ_GET, '0, '0, '0, 1'b0);
    endtask

    task automatic test_full_stall();
        write_marker(32'h7fff_ffff);
        send_request(mmf_pkg::REQ_FLUSH, '0, '0, '0, 1'b0);
        send_request(mmf_pkg::REQ_START, '0, '0, '0, 1'b0);
        hold_off_req = 1'b1;
        repeat (80) send_request(mmf_pkg::REQ_PUT, pick_type(), $urandom, $urandom,
                                 1'($urandom_range(0, 1)));
        send_request(mmf_pkg::REQ_PURGE, pick_type(), '0, '0, 1'b0);
        repeat (5) send_request(mmf_pkg::REQ_GET, '0, '0, '0, 1'b0);
        drain_mailbox();
    endtask

    task automatic test_random_traffic();
        logic [31:0] markers [4];
        markers = '{32'h0000_0000, $urandom, 32'hffff_ffff, $urandom};
        for (int phase = 0; phase < 4; phase++) begin
            write_marker(markers[phase]);
            quiet = (phase == 2);
            repeat (130) send_random_request();
        end
        quiet = 1'b0;
    endtask

    initial begin
        i_rst_n           = 1'b0;
        cfg_wr_en         = 1'b0;
        cfg_wr_data       = '0;
        req_bus.valid     = 1'b0;
        req_bus.req_type  = '0;
        req_bus.msg_type  = '0;
        req_bus.msg_arg_a = '0;
        req_bus.msg_arg_b = '0;
        req_bus.wait_flag = 1'b0;
        rsp_bus.ready     = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_aborted_after_reset();
        test_marker_and_extremes();
        test_held_get();
        test_purge_order();
        test_full_stall();
        test_random_traffic();
        drain_mailbox();

        if (mismatch_count == 0 && pending_rsps.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
